FILE: src/figcr_pkg.sv
`timescale 1ns / 1ps

package figcr_pkg;

    localparam int MAX_ZERO_RUN = 16;
    localparam int ZR_W         = $clog2(MAX_ZERO_RUN + 1);
    localparam int MAX_RESULTS  = 4;
    localparam int RES_IDX_W    = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int FIVE_CELLS   = 5;
    localparam int FIVE_W       = $clog2(FIVE_CELLS);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] COUNT_SAT  = 4'hf;
    localparam logic [3:0] RAW_GROUP  = 4'd8;
    localparam logic [3:0] CODE_GROUP = 4'd5;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ONES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE     = 3'd4;

    localparam logic [1:0] CMD_GLITCH = 2'd0;
    localparam logic [1:0] CMD_FIVE   = 2'd1;
    localparam logic [1:0] CMD_TRANS  = 2'd2;

    typedef struct packed {
        logic [15:0] cell_length;
        logic [15:0] max_interval;
        logic [15:0] glitch_limit;
        logic [3:0]  sync_ones;
        logic        raw_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] interval;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       raw;
    } result_t;

    typedef struct packed {
        logic       full;
        logic       empty;
    } queue_stat_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } lookup_t;

    function automatic lookup_t code_to_nibble(input logic [4:0] code);
        lookup_t r;
        r.valid = 1'b1;
        case (code)
            5'd9:    r.nibble = 4'h8;
            5'd10:   r.nibble = 4'h0;
            5'd11:   r.nibble = 4'h1;
            5'd13:   r.nibble = 4'hc;
            5'd14:   r.nibble = 4'h4;
            5'd15:   r.nibble = 4'h5;
            5'd18:   r.nibble = 4'h2;
            5'd19:   r.nibble = 4'h3;
            5'd21:   r.nibble = 4'hf;
            5'd22:   r.nibble = 4'h6;
            5'd23:   r.nibble = 4'h7;
            5'd25:   r.nibble = 4'h9;
            5'd26:   r.nibble = 4'ha;
            5'd27:   r.nibble = 4'hb;
            5'd29:   r.nibble = 4'hd;
            5'd30:   r.nibble = 4'he;
            default:
            begin
                r.valid  = 1'b0;
                r.nibble = 4'h0;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: src/figcr_if.sv
`timescale 1ns / 1ps

interface figcr_flux_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] interval;

    modport source (output valid, output action, output interval, input ready);
    modport sink (input valid, input action, input interval, output ready);
endinterface

interface figcr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       bad_code;
    logic       is_raw;
    logic       last;

    modport source (output valid, output data_out, output bad_code, output is_raw,
                    output last, input ready);
    modport sink (input valid, input data_out, input bad_code, input is_raw,
                  input last, output ready);
endinterface

FILE: src/figcr_front.sv
`timescale 1ns / 1ps

module figcr_front
    import figcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    figcr_flux_if.sink            flux,
    input  queue_stat_t           qstat,
    output logic                  push,
    output cmd_t                  push_cmd,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic drop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CELL_LENGTH:  cfg_next.cell_length  = cfg_data;
                CFG_MAX_INTERVAL: cfg_next.max_interval = cfg_data;
                CFG_GLITCH_LIMIT: cfg_next.glitch_limit = cfg_data;
                CFG_SYNC_ONES:    cfg_next.sync_ones    = cfg_data[3:0];
                CFG_RAW_MODE:     cfg_next.raw_mode     = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_length  <= 16'd280;
            cfg_reg.max_interval <= 16'd2240;
            cfg_reg.glitch_limit <= 16'd200;
            cfg_reg.sync_ones    <= 4'd10;
            cfg_reg.raw_mode     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify the transaction
    always_comb
    begin
        drop              = 1'b0;
        push_cmd.interval = flux.interval;
        if (flux.action)
        begin
            push_cmd.kind = CMD_FIVE;
        end
        else if (flux.interval < cfg_reg.glitch_limit)
        begin
            push_cmd.kind = CMD_GLITCH;
        end
        else
        begin
            push_cmd.kind = CMD_TRANS;
            drop          = (flux.interval > cfg_reg.max_interval);
        end
    end

    assign flux.ready = !qstat.full;
    assign push       = flux.valid && !qstat.full && !drop;
    assign cfg        = cfg_reg;

endmodule

FILE: src/figcr_fifo.sv
`timescale 1ns / 1ps

module figcr_fifo
    import figcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_cmd,
    input  logic        pop,
    output cmd_t        head,
    output queue_stat_t qstat
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    assign head        = mem_reg[rd_reg];
    assign qstat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != QCNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("queue pop while empty");
`endif

endmodule

FILE: src/figcr_back.sv
`timescale 1ns / 1ps

module figcr_back
    import figcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        head,
    input  queue_stat_t qstat,
    output logic        pop,
    figcr_res_if.source res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [1:0]           kind_reg;
    logic [1:0]           kind_next;
    logic [15:0]          diff_reg;
    logic [15:0]          diff_next;
    logic [ZR_W-1:0]      zeros_reg;
    logic [ZR_W-1:0]      zeros_next;
    logic [FIVE_W-1:0]    five_reg;
    logic [FIVE_W-1:0]    five_next;
    logic [RES_CNT_W-1:0] rcnt_reg;
    logic [RES_CNT_W-1:0] rcnt_next;
    logic [RES_IDX_W-1:0] rd_reg;
    logic [RES_IDX_W-1:0] rd_next;

    logic                 in_sync_reg;
    logic                 in_sync_next;
    logic [3:0]           ones_reg;
    logic [3:0]           ones_next;
    logic [3:0]           bc_reg;
    logic [3:0]           bc_next;
    logic [7:0]           shift_reg;
    logic [7:0]           shift_next;

    result_t              rbuf_reg [MAX_RESULTS];

    logic                 cell_bit;
    logic                 c_sync;
    logic [3:0]           c_ones;
    logic [3:0]           c_bc;
    logic [7:0]           c_shift;
    logic                 emit;
    result_t              emit_res;
    logic                 store;
    lookup_t              lk;
    logic [16:0]          limit;
    logic                 take_zero;
    logic                 done;

    assign limit     = {1'b0, cfg.cell_length} + {2'b00, cfg.cell_length[15:1]};
    assign take_zero = ({1'b0, diff_reg} > limit) && (zeros_reg < ZR_W'(MAX_ZERO_RUN));

    // one bit cell
    always_comb
    begin
        c_sync   = in_sync_reg;
        c_ones   = ones_reg;
        c_bc     = bc_reg;
        emit     = 1'b0;
        emit_res = '0;
        lk       = '0;
        if (!cell_bit)
        begin
            if (ones_reg >= cfg.sync_ones)
            begin
                c_bc   = '0;
                c_sync = 1'b1;
            end
            c_ones  = '0;
            c_shift = {shift_reg[6:0], 1'b0};
        end
        else
        begin
            c_shift = {shift_reg[6:0], 1'b1};
            if (ones_reg != COUNT_SAT)
            begin
                c_ones = ones_reg + 4'd1;
            end
        end
        if (c_bc != COUNT_SAT)
        begin
            c_bc = c_bc + 4'd1;
        end
        if (c_sync)
        begin
            if (cfg.raw_mode)
            begin
                if (c_bc == RAW_GROUP)
                begin
                    emit          = 1'b1;
                    emit_res.data = c_shift;
                    emit_res.raw  = 1'b1;
                    c_bc          = '0;
                    c_shift       = '0;
                end
            end
            else if (c_bc == CODE_GROUP)
            begin
                lk            = code_to_nibble(c_shift[4:0]);
                emit          = 1'b1;
                emit_res.data = lk.valid ? {4'h0, lk.nibble} : 8'h00;
                emit_res.bad  = !lk.valid;
                c_bc          = '0;
                c_shift       = '0;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        diff_next    = diff_reg;
        zeros_next   = zeros_reg;
        five_next    = five_reg;
        rcnt_next    = rcnt_reg;
        rd_next      = rd_reg;
        in_sync_next = in_sync_reg;
        ones_next    = ones_reg;
        bc_next      = bc_reg;
        shift_next   = shift_reg;
        pop          = 1'b0;
        cell_bit     = 1'b0;
        done         = 1'b0;
        store        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    kind_next  = head.kind;
                    diff_next  = head.interval;
                    zeros_next = '0;
                    five_next  = '0;
                    rcnt_next  = '0;
                    rd_next    = '0;
                    if (head.kind == CMD_GLITCH)
                    begin
                        in_sync_next = 1'b0;
                        ones_next    = '0;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (kind_reg == CMD_FIVE)
                begin
                    cell_bit  = 1'b0;
                    done      = (five_reg == FIVE_W'(FIVE_CELLS - 1));
                    five_next = five_reg + FIVE_W'(1);
                end
                else if (take_zero)
                begin
                    cell_bit   = 1'b0;
                    diff_next  = diff_reg - cfg.cell_length;
                    zeros_next = zeros_reg + ZR_W'(1);
                end
                else
                begin
                    cell_bit = 1'b1;
                    done     = 1'b1;
                end
                in_sync_next = c_sync;
                ones_next    = c_ones;
                bc_next      = c_bc;
                shift_next   = c_shift;
                store        = emit && (rcnt_reg != RES_CNT_W'(MAX_RESULTS));
                if (store)
                begin
                    rcnt_next = rcnt_reg + RES_CNT_W'(1);
                end
                if (done)
                begin
                    state_next = (rcnt_next != '0) ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (res.ready)
                begin
                    if (res.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_next = rd_reg + RES_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kind_reg    <= CMD_GLITCH;
            zeros_reg   <= '0;
            five_reg    <= '0;
            rcnt_reg    <= '0;
            rd_reg      <= '0;
            in_sync_reg <= 1'b0;
            ones_reg    <= '0;
            bc_reg      <= '0;
            shift_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            zeros_reg   <= zeros_next;
            five_reg    <= five_next;
            rcnt_reg    <= rcnt_next;
            rd_reg      <= rd_next;
            in_sync_reg <= in_sync_next;
            ones_reg    <= ones_next;
            bc_reg      <= bc_next;
            shift_reg   <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        if (store)
        begin
            rbuf_reg[rcnt_reg[RES_IDX_W-1:0]] <= emit_res;
        end
    end

    assign res.valid    = (state_reg == ST_DRAIN);
    assign res.data_out = rbuf_reg[rd_reg].data;
    assign res.bad_code = rbuf_reg[rd_reg].bad;
    assign res.is_raw   = rbuf_reg[rd_reg].raw;
    assign res.last     = (({1'b0, rd_reg} + RES_CNT_W'(1)) == rcnt_reg);

`ifndef ASSERT_OFF
    a_drain_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (rcnt_reg != '0)
            && ({1'b0, rd_reg} < rcnt_reg))
        else $error("drain index outside stored results");
    a_zero_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        zeros_reg <= ZR_W'(MAX_ZERO_RUN))
        else $error("zero run past bound");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE) && !res.valid)
        else $error("command taken while busy");
`endif

endmodule

FILE: src/flux_interval_gcr_decoder_top.sv
`timescale 1ns / 1ps

// flux interval gcr decoder: flux transactions are classified combinationally and queued
// (four deep), so the input keeps accepting until the queue is full while the cell engine
// works. the engine pops a command only while idle, then handles one bit cell per cycle:
// five cells for a no-transition mark, the zero cells plus one for a transition (at most
// MAX_ZERO_RUN zeros), then delivers each decoded group (up to four, each waiting on
// res.ready). glitches clear sync while idle, overlong intervals are dropped at the input.
// the cell engine and the result delivery set the sustained rate.
module flux_interval_gcr_decoder_top
    import figcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    figcr_flux_if.sink            flux,
    figcr_res_if.source           res
);

    cfg_t        cfg;
    queue_stat_t qstat;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    cmd_t        head;

    figcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flux      (flux),
        .qstat     (qstat),
        .push      (push),
        .push_cmd  (push_cmd),
        .cfg       (cfg)
    );

    figcr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    figcr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .res   (res)
    );

endmodule

FILE: tb/tb_flux_interval_gcr_decoder_top.sv
`timescale 1ns / 1ps

module tb_flux_interval_gcr_decoder_top;
    import figcr_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       raw;
        logic       last;
    } gcr_out_t;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 150;
    localparam int MAX_PRINTS    = 40;

    // gcr 4-to-5 code table: valid codes and their nibbles, code 31 in the top nibble
    localparam logic [31:0]  GCR_VALID   = 32'h6EEC_EE00;
    localparam logic [127:0] GCR_NIBBLES = 128'h0ED0_BA90_76F0_3200_54C0_1080_0000_0000;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    figcr_flux_if flux_ch ();
    figcr_res_if  res_ch ();

    flux_interval_gcr_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flux      (flux_ch),
        .res       (res_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cfg_t        cur_cfg;
    logic        in_sync    = 1'b0;
    logic [3:0]  ones_run   = 4'd0;
    logic [3:0]  bit_count  = 4'd0;
    logic [7:0]  shift_bits = 8'd0;
    gcr_out_t    item_groups[$];
    gcr_out_t    gcr_expected[$];

    int error_count    = 0;
    int flux_sent      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    function automatic cfg_t make_cfg(input int unsigned cell_len, input int unsigned mx,
                                      input int unsigned gl, input int unsigned so,
                                      input int unsigned raw);
        cfg_t c;
        c.cell_length  = 16'(cell_len);
        c.max_interval = 16'(mx);
        c.glitch_limit = 16'(gl);
        c.sync_ones    = 4'(so);
        c.raw_mode     = 1'(raw);
        return c;
    endfunction

    function automatic void add_group(input logic [7:0] data, input logic bad, input logic raw);
        if (item_groups.size() < MAX_RESULTS)
            item_groups.push_back('{data: data, bad: bad, raw: raw, last: 1'b0});
    endfunction

    function automatic void shift_cell(input logic b);
        logic [4:0] code;
        if (!b)
        begin
            if (ones_run >= cur_cfg.sync_ones)
            begin
                bit_count = 4'd0;
                in_sync   = 1'b1;
            end
            ones_run = 4'd0;
        end
        else if (ones_run != COUNT_SAT)
            ones_run = ones_run + 4'd1;
        shift_bits = {shift_bits[6:0], b};
        if (bit_count != COUNT_SAT)
            bit_count = bit_count + 4'd1;
        if (in_sync)
        begin
            if (cur_cfg.raw_mode)
            begin
                if (bit_count == RAW_GROUP)
                begin
                    bit_count = 4'd0;
                    add_group(shift_bits, 1'b0, 1'b1);
                    shift_bits = 8'd0;
                end
            end
            else if (bit_count == CODE_GROUP)
            begin
                code      = shift_bits[4:0];
                bit_count = 4'd0;
                if (GCR_VALID[code])
                    add_group({4'd0, GCR_NIBBLES[code*4 +: 4]}, 1'b0, 1'b0);
                else
                    add_group(8'd0, 1'b1, 1'b0);
                shift_bits = 8'd0;
            end
        end
    endfunction

    function automatic void predict_flux(input logic act, input logic [15:0] ivl);
        int unsigned rest;
        int unsigned lim;
        int          zeros;
        item_groups.delete();
        if (act)
        begin
            repeat (5) shift_cell(1'b0);
        end
        else if (ivl < cur_cfg.glitch_limit)
        begin
            in_sync  = 1'b0;
            ones_run = 4'd0;
        end
        else if (ivl <= cur_cfg.max_interval)
        begin
            rest  = ivl;
            lim   = cur_cfg.cell_length + (cur_cfg.cell_length >> 1);
            zeros = 0;
            while (rest > lim && zeros < MAX_ZERO_RUN)
            begin
                shift_cell(1'b0);
                rest  = rest - cur_cfg.cell_length;
                zeros = zeros + 1;
            end
            shift_cell(1'b1);
        end
        foreach (item_groups[i])
        begin
            item_groups[i].last = (i == item_groups.size() - 1);
            gcr_expected.push_back(item_groups[i]);
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        gcr_out_t got;
        gcr_out_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.data_out, res_ch.bad_code, res_ch.is_raw, res_ch.last};
            if (gcr_expected.size() == 0)
                report_mismatch($sformatf("unexpected result data %h bad %b raw %b last %b",
                                          got.data, got.bad, got.raw, got.last));
            else
            begin
                want = gcr_expected.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "data %h/%h bad %b/%b raw %b/%b last %b/%b (got/exp)",
                        got.data, want.data, got.bad, want.bad, got.raw, want.raw,
                        got.last, want.last));
            end
        end
    end

    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic configure(input cfg_t c);
        write_reg(CFG_CELL_LENGTH, c.cell_length);
        write_reg(CFG_MAX_INTERVAL, c.max_interval);
        write_reg(CFG_GLITCH_LIMIT, c.glitch_limit);
        write_reg(CFG_SYNC_ONES, {12'd0, c.sync_ones});
        write_reg(CFG_RAW_MODE, {15'd0, c.raw_mode});
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic push_flux(input logic act, input logic [15:0] ivl);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            flux_ch.valid <= 1'b0;
            @(negedge clk);
        end
        flux_ch.valid    <= 1'b1;
        flux_ch.action   <= act;
        flux_ch.interval <= ivl;
        @(posedge clk);
        while (!flux_ch.ready)
            @(posedge clk);
        predict_flux(act, ivl);
        flux_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        flux_ch.valid <= 1'b0;
        while (gcr_expected.size() != 0)
            @(negedge clk);
        // transactions that give no result may still sit in the input queue
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [15:0] cell_interval(input int n);
        int c;
        int j;
        int v;
        c = cur_cfg.cell_length;
        j = c / 5;
        v = n * c + int'($urandom_range(0, 2 * j)) - j;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    task automatic send_gcr_burst(input int ones, input int n_data);
        repeat (ones) push_flux(1'b0, cell_interval(1));
        push_flux(1'b0, cell_interval(2));
        repeat (n_data)
        begin
            if ($urandom_range(0, 9) == 0)
                push_flux(1'b1, 16'($urandom));
            else
                push_flux(1'b0, cell_interval($urandom_range(1, 3)));
        end
    endtask

    task automatic run_flux_phase(input cfg_t c, input int n_items, input int idle_pct,
                                  input int stall_pct);
        int stop_at;
        int pick;
        configure(c);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = flux_sent + n_items;
        while (flux_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                push_flux(1'($urandom), 16'($urandom));
            else if (pick < 20)
                send_gcr_burst($urandom_range(0, cur_cfg.sync_ones), $urandom_range(2, 6));
            else
                send_gcr_burst(cur_cfg.sync_ones + $urandom_range(0, 2), $urandom_range(4, 14));
        end
        drain();
    endtask

    task automatic test_reset_values();
        repeat (10) push_flux(1'b0, 16'd280);
        push_flux(1'b0, 16'd560);
        push_flux(1'b0, 16'd840);
        push_flux(1'b1, 16'hffff);
        push_flux(1'b0, 16'd200);
        push_flux(1'b0, 16'd199);
        push_flux(1'b0, 16'd2240);
        push_flux(1'b0, 16'd2241);
        push_flux(1'b0, 16'd0);
        push_flux(1'b0, 16'hffff);
        drain();
    endtask

    task automatic test_extremes();
        configure(make_cfg(100, 65535, 0, 1, 0));
        push_flux(1'b0, 16'd0);
        push_flux(1'b0, 16'd200);
        push_flux(1'b0, 16'd300);
        repeat (3) push_flux(1'b0, 16'd100);
        push_flux(1'b0, 16'hffff);
        push_flux(1'b1, 16'd0);
        drain();
    endtask

    task automatic test_zero_cell_length();
        configure(make_cfg(0, 65535, 0, 0, 1));
        push_flux(1'b0, 16'hffff);
        repeat (6) push_flux(1'b0, 16'd0);
        push_flux(1'b1, 16'h5a5a);
        push_flux(1'b0, 16'd1);
        drain();
    endtask

    task automatic test_random_no_idle();
        run_flux_phase(make_cfg(1, 65535, 0, 15, 0), 40, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_flux_phase(make_cfg(280, 2240, 200, 10, 1), 40, 64, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_flux_phase(make_cfg(65535, 65535, 65535, 1, 0), 40, 0, 64);
    endtask

    task automatic test_random_both_idle();
        int unsigned cell_len;
        int unsigned mx;
        cell_len = $urandom_range(40, 3000);
        mx       = cell_len * $urandom_range(2, 20);
        if (mx > 65535)
            mx = 65535;
        run_flux_phase(make_cfg(cell_len, mx, $urandom_range(0, cell_len / 2),
                                $urandom_range(1, 15), $urandom_range(0, 1)), 40, 7, 7);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        cur_cfg          = make_cfg(280, 2240, 200, 10, 0);
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_CELL_LENGTH;
        cfg_data         = '0;
        flux_ch.valid    = 1'b0;
        flux_ch.action   = 1'b0;
        flux_ch.interval = '0;
        res_ch.ready     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_extremes();
        test_zero_cell_length();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
